FILE: design/assert_macros.svh
// Assertion macros shared by the steering core RTL.
// Expects clk and rst (active high) in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define HPDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HPDS_ASSERT_NEXT(label, ante, cons, msg) \
  `HPDS_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: design/hpds_pkg.sv
// Types, constants and the CORDIC angle table for the heading PD steering core.
// No dependencies; imported by the CORDIC cell and the top level.
`default_nettype none

package hpds_pkg;

  localparam int POS_BITS     = 24;
  localparam int CORDIC_STEPS = 16;

  localparam int STEP_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int DIFF_W   = POS_BITS + 1;
  localparam int SCALE_SH = 26;
  localparam int XY_W     = DIFF_W + SCALE_SH + 3;
  localparam int Z_W      = 26;
  localparam int BEAR_W   = 16;
  localparam int ERR_W    = 15;
  localparam int E0_W     = 17;

  localparam int HALF_TURN    = 11520;
  localparam int FULL_TURN    = 23040;
  localparam int STRENGTH_ONE = 4096;
  localparam int HALF_Q16     = 180 * 65536;
  localparam int ROUND_HALF   = 512;
  localparam int ROUND_SH     = 10;

  localparam int REM_MULT  = 93207;
  localparam int REM_SHIFT = 25;
  localparam int DEG_MOD   = 360;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 8'd3;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cord_t;

  function automatic logic signed [Z_W-1:0] atan_angle(input int i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      0:       a = 26'sd2949120;
      1:       a = 26'sd1740967;
      2:       a = 26'sd919879;
      3:       a = 26'sd466945;
      4:       a = 26'sd234379;
      5:       a = 26'sd117304;
      6:       a = 26'sd58666;
      7:       a = 26'sd29335;
      8:       a = 26'sd14668;
      9:       a = 26'sd7334;
      10:      a = 26'sd3667;
      11:      a = 26'sd1833;
      12:      a = 26'sd917;
      13:      a = 26'sd458;
      14:      a = 26'sd229;
      15:      a = 26'sd115;
      16:      a = 26'sd57;
      17:      a = 26'sd29;
      18:      a = 26'sd14;
      19:      a = 26'sd7;
      20:      a = 26'sd4;
      21:      a = 26'sd2;
      22:      a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/hpds_cordic_cell.sv
// One CORDIC vectoring step: rotate toward y = 0 and accumulate the angle.
// Depends on hpds_pkg for cord_t and the datapath widths.
`default_nettype none

module hpds_cordic_cell
  import hpds_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [STEP_W-1:0]        step_idx,
  input  wire logic signed [Z_W-1:0]    angle,
  input  wire cord_t                    din,
  output cord_t                         dout
);

  logic signed [XY_W-1:0] xi, yi, xs, ys, nx, ny, x_r, y_r;
  logic signed [Z_W-1:0]  zi, nz, z_r;
  logic                   vld;

  assign xi = din.x;
  assign yi = din.y;
  assign zi = din.z;

  always_comb begin
    xs = xi >>> step_idx;
    ys = yi >>> step_idx;
    if (!yi[XY_W-1]) begin
      nx = xi + ys;
      ny = yi - xs;
      nz = zi + angle;
    end else begin
      nx = xi - ys;
      ny = yi + xs;
      nz = zi - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= nx;
    y_r <= ny;
    z_r <= nz;
  end

  assign dout = '{valid: vld, x: x_r, y: y_r, z: z_r};

endmodule

`default_nettype wire

FILE: design/heading_pd_steering_core.sv
// Top level of the heading PD steering core: stream ports, config registers,
// CORDIC cell chain, heading reduction and PD post stages. Uses hpds_pkg,
// hpds_cordic_cell and assert_macros.svh.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[111:0]
//  m_axis    out  m_axis_tvalid/tready       tdata[31:0]
//  cfg       in   cfg_valid/cfg_ready        cfg_index[7:0], cfg_data[15:0]
//
// One item at a time: an accepted beat passes through the start register, the CORDIC cell chain
// (one cell per step), five PD stages and the output register.
// A new beat is taken the cycle after the result enters the output register.
// Synchronous reset clears control and the previous error and loads the config registers with defaults.
// A stalled output holds the result in a finished stage; cfg_ready is always high.
`default_nettype none

`include "assert_macros.svh"

module heading_pd_steering_core
  import hpds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // target_x[23:0], target_y[47:24], vehicle_x[71:48], vehicle_y[95:72],
  // heading_deg[111:96]
  input  wire logic [4*POS_BITS+15:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // turn_strength[12:0], turn_dir[14:13], heading_error[29:15], zero[31:30]
  output logic [31:0]                m_axis_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] prop_gain, deriv_gain;
  logic [12:0] strength_limit;
  logic [13:0] deadband;

  logic busy, start;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [15:0]       hd;
  logic                     tgt_zero;
  logic [15:0]              hd_abs;
  logic [32:0]              hd_prod;
  logic [6:0]               hd_q;
  logic [8:0]               hd_r;
  logic signed [15:0]       hd_rem64;

  logic signed [POS_BITS-1:0] tx, ty, vx, vy;
  logic signed [XY_W-1:0]     xe, ye;
  cord_t                      chain_head;
  cord_t                      chain [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]      chain_vld;

  logic v1, v2, v3, v4, done_valid;
  logic signed [BEAR_W-1:0] bear;
  logic signed [E0_W-1:0]   e0, w1, w2;
  logic signed [ERR_W-1:0]  err2, err3, prev_error;
  logic signed [15:0]       diff;
  logic signed [31:0]       prod_p;
  logic signed [32:0]       prod_d;
  logic signed [33:0]       pd_sum;
  logic [32:0]              mag;
  logic [23:0]              strength_raw;
  logic [12:0]              lim;
  dir_t                     dir3, dir4, dir_next;
  logic signed [ERR_W-1:0]  err4;
  logic [12:0]              done_strength;
  dir_t                     done_dir;
  logic signed [ERR_W-1:0]  done_err;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= 16'd655;
      deriv_gain     <= 16'd655;
      strength_limit <= 13'd4096;
      deadband       <= 14'd192;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:      prop_gain      <= cfg_data;
        REG_DERIV_GAIN:     deriv_gain     <= cfg_data;
        REG_STRENGTH_LIMIT: strength_limit <= cfg_data[12:0];
        REG_DEADBAND:       deadband       <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  assign tx = s_axis_tdata[POS_BITS-1:0];
  assign ty = s_axis_tdata[2*POS_BITS-1:POS_BITS];
  assign vx = s_axis_tdata[3*POS_BITS-1:2*POS_BITS];
  assign vy = s_axis_tdata[4*POS_BITS-1:3*POS_BITS];

  // capture the beat and hold it for the whole item
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      dx       <= DIFF_W'(tx) - DIFF_W'(vx);
      dy       <= DIFF_W'(ty) - DIFF_W'(vy);
      tgt_zero <= (tx == vx) && (ty == vy);
      hd       <= s_axis_tdata[4*POS_BITS+15:4*POS_BITS];
    end
  end

  // heading rem 360 by reciprocal multiply, ready long before the chain ends
  assign hd_abs  = hd[15] ? 16'(-hd) : 16'(hd);
  assign hd_prod = 33'(hd_abs) * 33'(REM_MULT);

  always_ff @(posedge clk) begin
    hd_q     <= 7'(hd_prod >> REM_SHIFT);
    hd_r     <= 9'(hd_abs - 16'(hd_q) * 16'(DEG_MOD));
    hd_rem64 <= hd[15] ? -$signed({1'b0, hd_r, 6'b0}) : $signed({1'b0, hd_r, 6'b0});
  end

  // fold the left half plane onto the right before the first cell
  assign xe = XY_W'(dx) <<< SCALE_SH;
  assign ye = XY_W'(dy) <<< SCALE_SH;

  always_comb begin
    chain_head.valid = start;
    if (dx[DIFF_W-1]) begin
      chain_head.x = -xe;
      chain_head.y = -ye;
      chain_head.z = dy[DIFF_W-1] ? -Z_W'(HALF_Q16) : Z_W'(HALF_Q16);
    end else begin
      chain_head.x = xe;
      chain_head.y = ye;
      chain_head.z = '0;
    end
  end

  assign chain[0]     = chain_head;
  assign chain_vld[0] = chain[0].valid;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    hpds_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step_idx (STEP_W'(g)),
      .angle    (atan_angle(g)),
      .din      (chain[g]),
      .dout     (chain[g+1])
    );
    assign chain_vld[g+1] = chain[g+1].valid;
  end

  // bearing, error and wrap
  always_comb begin
    bear = BEAR_W'((chain[CORDIC_STEPS].z + Z_W'(ROUND_HALF)) >>> ROUND_SH);
    if (tgt_zero) begin
      bear = '0;
    end
    w1 = e0;
    if (w1 > HALF_TURN) begin
      w1 = w1 - E0_W'(FULL_TURN);
    end else if (w1 < -HALF_TURN) begin
      w1 = w1 + E0_W'(FULL_TURN);
    end
    w2 = w1;
    if (w2 > HALF_TURN) begin
      w2 = w2 - E0_W'(FULL_TURN);
    end else if (w2 < -HALF_TURN) begin
      w2 = w2 + E0_W'(FULL_TURN);
    end
  end

  assign diff = 16'(err2) - 16'(prev_error);

  always_comb begin
    if (err2 > $signed({2'b0, deadband})) begin
      dir_next = DIR_LEFT;
    end else if (err2 < -$signed({2'b0, deadband})) begin
      dir_next = DIR_RIGHT;
    end else begin
      dir_next = DIR_NONE;
    end
  end

  assign pd_sum       = 34'(prod_p) + 34'(prod_d);
  assign strength_raw = 24'((mag + 33'(ROUND_HALF)) >> ROUND_SH);
  assign lim          = (strength_limit > 13'(STRENGTH_ONE)) ? 13'(STRENGTH_ONE)
                                                              : strength_limit;

  always_ff @(posedge clk) begin
    e0     <= E0_W'(bear) - E0_W'(hd_rem64);
    err2   <= ERR_W'(w2);
    prod_p <= err2 * $signed({1'b0, prop_gain});
    prod_d <= diff * $signed({1'b0, deriv_gain});
    err3   <= err2;
    dir3   <= dir_next;
    mag    <= pd_sum[33] ? 33'(-pd_sum) : 33'(pd_sum);
    err4   <= err3;
    dir4   <= dir3;
    if (v4) begin
      done_strength <= (strength_raw > 24'(lim)) ? lim : 13'(strength_raw);
      done_dir      <= dir4;
      done_err      <= err4;
    end
    if (done_valid && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {2'b0, done_err, done_dir, done_strength};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      start         <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      done_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      prev_error    <= '0;
    end else begin
      start <= s_axis_tvalid && s_axis_tready;
      v1    <= chain[CORDIC_STEPS].valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      if (v2) begin
        prev_error <= err2;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        busy <= 1'b1;
      end
      if (done_valid && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        done_valid    <= 1'b0;
        busy          <= 1'b0;
      end else begin
        if (v4) begin
          done_valid <= 1'b1;
        end
        if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  `HPDS_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, busy && !s_axis_tready, "accepted beat did not mark the core busy")
  `HPDS_ASSERT(a_one_in_flight, $onehot0({chain_vld, v1, v2, v3, v4, done_valid}), "more than one item in flight")
  `HPDS_ASSERT(a_work_busy, ((|chain_vld) || v1 || v2 || v3 || v4 || done_valid) |-> busy, "stage active while core idle")
  `HPDS_ASSERT_NEXT(a_done_moves, done_valid && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && !done_valid && !busy, "finished result did not move to the output")

endmodule

`default_nettype wire
